@@ src/fcc_pkg.sv @@
// Shared types, widths and helpers for the floor/ceiling texel cast block.
// No dependencies; every other file in src uses this package.
package fcc_pkg;

  localparam int ROW_W      = 11;
  localparam int SIZE_W     = 11;
  localparam int TEX_W      = 10;
  localparam int IDX_W      = 20;
  localparam int POS_W      = 24;
  localparam int PT_W       = 25;
  localparam int DEN_W      = 36;
  localparam int NUM_W      = 52;
  localparam int FACT_W     = 32;
  localparam int CMAG_W     = 34;
  localparam int M_W        = 28;
  localparam int DIV_STEPS  = 32;
  localparam int MOD_STEPS  = 28;
  localparam int FIFO_DEPTH = 4;

  localparam logic [SIZE_W-1:0] SIZE_MAX = 11'd1024;

  // APB register indexes (paddr[4:2])
  localparam logic [2:0] REG_VIEW_OFFSET = 3'd0;
  localparam logic [2:0] REG_FLOOR_TEX_W = 3'd1;
  localparam logic [2:0] REG_FLOOR_TEX_H = 3'd2;
  localparam logic [2:0] REG_CEIL_TEX_W  = 3'd3;
  localparam logic [2:0] REG_CEIL_TEX_H  = 3'd4;

  typedef enum logic [1:0] {
    FACE_X_POS = 2'd0,
    FACE_X_NEG = 2'd1,
    FACE_Y_POS = 2'd2,
    FACE_Y_NEG = 2'd3
  } fcc_face_e;

  // per-item data that rides along with the arithmetic
  typedef struct packed {
    logic              ok;
    logic [ROW_W-1:0]  col;
    logic [ROW_W-1:0]  sy;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } fcc_side_t;

  // classified item as queued between front and back
  typedef struct packed {
    fcc_side_t        side;
    logic [PT_W-1:0]  fx;
    logic [PT_W-1:0]  fy;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [DEN_W-1:0] den;
  } fcc_item_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) r = 11'd1;
    else if (s > SIZE_MAX) r = SIZE_MAX;
    return r;
  endfunction

endpackage

@@ src/floor_ceiling_texel_cast_top.sv @@
// Top level of the floor/ceiling texel cast block: APB registers, front end,
// queue and back end. Depends on fcc_pkg, fcc_front, fcc_fifo, fcc_back.
//
// One pixel request in, one result out, at a sustained rate of one request
// per clock while out_stall_i is low. From acceptance to out_valid_o, the
// request is written into the four-entry queue at the accepting edge, then
// passes 33 stages of the bit-per-stage divider that forms the Q8.24
// distance factor, four blend/scale stages, 29 stages of the bit-per-stage
// texel remainder and the output register. A stalled output
// freezes the whole back end; the queue keeps accepting until it holds four
// requests, then in_stall_o rises. Requests outside the cast range (or with
// 2*row <= SCREEN_HEIGHT) come out with in_range_o low and all other fields
// zero. Registers sit at byte addresses 0,4,8,12,16 (view offset, floor
// width, floor height, ceiling width, ceiling height) and should be written
// only while the block is drained; size registers of 0 act as 1 and sizes
// above 1024 act as 1024.
module floor_ceiling_texel_cast_top #(
  parameter int SCREEN_HEIGHT = 720
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [1:0]  hit_face_i,
  input  logic [7:0]  cell_x_i,
  input  logic [7:0]  cell_y_i,
  input  logic [15:0] wall_frac_i,
  input  logic [23:0] wall_dist_i,
  input  logic [23:0] player_x_i,
  input  logic [23:0] player_y_i,
  input  logic [10:0] wall_bottom_i,
  input  logic [10:0] row_i,
  input  logic [10:0] column_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] screen_x_o,
  output logic [10:0] screen_y_o,
  output logic [9:0]  tex_x_o,
  output logic [9:0]  tex_y_o,
  output logic [19:0] texel_index_o,
  output logic        in_range_o
);

  // configuration registers
  logic [9:0]  view_offset_q;
  logic [10:0] floor_w_q, floor_h_q, ceil_w_q, ceil_h_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_offset_q <= '0;
      floor_w_q     <= 11'd64;
      floor_h_q     <= 11'd64;
      ceil_w_q      <= 11'd64;
      ceil_h_q      <= 11'd64;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        fcc_pkg::REG_VIEW_OFFSET: view_offset_q <= pwdata[9:0];
        fcc_pkg::REG_FLOOR_TEX_W: floor_w_q     <= pwdata[10:0];
        fcc_pkg::REG_FLOOR_TEX_H: floor_h_q     <= pwdata[10:0];
        fcc_pkg::REG_CEIL_TEX_W:  ceil_w_q      <= pwdata[10:0];
        fcc_pkg::REG_CEIL_TEX_H:  ceil_h_q      <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      fcc_pkg::REG_VIEW_OFFSET: prdata = 32'(view_offset_q);
      fcc_pkg::REG_FLOOR_TEX_W: prdata = 32'(floor_w_q);
      fcc_pkg::REG_FLOOR_TEX_H: prdata = 32'(floor_h_q);
      fcc_pkg::REG_CEIL_TEX_W:  prdata = 32'(ceil_w_q);
      fcc_pkg::REG_CEIL_TEX_H:  prdata = 32'(ceil_h_q);
      default:                  prdata = '0;
    endcase
  end

  // front end: classify and prepare the request
  fcc_pkg::fcc_item_t front_item, q_item;
  logic               q_full, q_empty, push, pop, back_en;

  fcc_front #(.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
    .req_type_i         (req_type_i),
    .hit_face_i         (hit_face_i),
    .cell_x_i           (cell_x_i),
    .cell_y_i           (cell_y_i),
    .wall_frac_i        (wall_frac_i),
    .wall_dist_i        (wall_dist_i),
    .player_x_i         (player_x_i),
    .player_y_i         (player_y_i),
    .wall_bottom_i      (wall_bottom_i),
    .row_i              (row_i),
    .column_i           (column_i),
    .view_offset_i      (view_offset_q),
    .floor_tex_width_i  (floor_w_q),
    .floor_tex_height_i (floor_h_q),
    .ceil_tex_width_i   (ceil_w_q),
    .ceil_tex_height_i  (ceil_h_q),
    .item_o             (front_item)
  );

  // stall only on a full queue; the back end drains independently
  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;
  // back end advances unless a finished result is held by the consumer
  assign back_en    = !(out_valid_o && out_stall_i);
  assign pop        = back_en && !q_empty;

  fcc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  fcc_back #(.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (back_en),
    .valid_i       (!q_empty),
    .item_i        (q_item),
    .out_valid_o   (out_valid_o),
    .screen_x_o    (screen_x_o),
    .screen_y_o    (screen_y_o),
    .tex_x_o       (tex_x_o),
    .tex_y_o       (tex_y_o),
    .texel_index_o (texel_index_o),
    .in_range_o    (in_range_o)
  );

endmodule

@@ src/fcc_front.sv @@
// Front end: cast-range check, floor point from the hit face, divisor and
// texture size selection. Depends on fcc_pkg.
module fcc_front #(
  parameter int SCREEN_HEIGHT = 720
) (
  input  logic                       req_type_i,
  input  logic [1:0]                 hit_face_i,
  input  logic [7:0]                 cell_x_i,
  input  logic [7:0]                 cell_y_i,
  input  logic [15:0]                wall_frac_i,
  input  logic [23:0]                wall_dist_i,
  input  logic [23:0]                player_x_i,
  input  logic [23:0]                player_y_i,
  input  logic [10:0]                wall_bottom_i,
  input  logic [10:0]                row_i,
  input  logic [10:0]                column_i,
  input  logic [9:0]                 view_offset_i,
  input  logic [10:0]                floor_tex_width_i,
  input  logic [10:0]                floor_tex_height_i,
  input  logic [10:0]                ceil_tex_width_i,
  input  logic [10:0]                ceil_tex_height_i,
  output fcc_pkg::fcc_item_t         item_o
);

  localparam logic signed [13:0] HS = 14'(SCREEN_HEIGHT);

  logic signed [13:0] y_s, wb_s, vo_s, sy_s, dy_s;
  logic               ok_rng, ok_half;
  logic [23:0]        wd;
  logic [11:0]        dy;
  logic [24:0]        cx, cy, frac;

  always_comb begin
    y_s  = $signed({3'b000, row_i});
    wb_s = $signed({3'b000, wall_bottom_i});
    vo_s = $signed({{4{view_offset_i[9]}}, view_offset_i});
    if (req_type_i) begin
      ok_rng = (y_s >= wb_s + 14'sd1) && (y_s < HS + vo_s);
      sy_s   = HS - y_s + vo_s;
    end else begin
      ok_rng = (y_s >= wb_s - 14'sd1) && (y_s + vo_s < HS);
      sy_s   = y_s + vo_s;
    end
    ok_half = (y_s + y_s) > HS;
    dy_s    = y_s + y_s - HS;
    dy      = dy_s[11:0];
    wd      = (wall_dist_i == '0) ? 24'd1 : wall_dist_i;

    cx   = {1'b0, cell_x_i, 16'h0000};
    cy   = {1'b0, cell_y_i, 16'h0000};
    frac = {9'd0, wall_frac_i};

    item_o.side.ok  = ok_rng && ok_half;
    item_o.side.col = column_i;
    item_o.side.sy  = sy_s[10:0];
    if (req_type_i) begin
      item_o.side.w = fcc_pkg::clamp_size(ceil_tex_width_i);
      item_o.side.h = fcc_pkg::clamp_size(ceil_tex_height_i);
    end else begin
      item_o.side.w = fcc_pkg::clamp_size(floor_tex_width_i);
      item_o.side.h = fcc_pkg::clamp_size(floor_tex_height_i);
    end

    unique case (fcc_pkg::fcc_face_e'(hit_face_i))
      fcc_pkg::FACE_X_POS: begin
        item_o.fx = cx;
        item_o.fy = cy + frac;
      end
      fcc_pkg::FACE_X_NEG: begin
        item_o.fx = cx + 25'h10000;
        item_o.fy = cy + frac;
      end
      fcc_pkg::FACE_Y_POS: begin
        item_o.fx = cx + frac;
        item_o.fy = cy;
      end
      default: begin
        item_o.fx = cx + frac;
        item_o.fy = cy + 25'h10000;
      end
    endcase

    item_o.px  = player_x_i;
    item_o.py  = player_y_i;
    item_o.den = 36'(dy) * 36'(wd);
  end

endmodule

@@ src/fcc_fifo.sv @@
// Short queue decoupling front and back ends.
// Depends on fcc_pkg for the item type and depth.
module fcc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fcc_pkg::fcc_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output fcc_pkg::fcc_item_t item_o
);

  localparam int AW = $clog2(fcc_pkg::FIFO_DEPTH);

  fcc_pkg::fcc_item_t mem_q [fcc_pkg::FIFO_DEPTH];
  logic [AW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]        cnt_q, cnt_d;

  assign full_o  = (cnt_q == (AW+1)'(fcc_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(fcc_pkg::FIFO_DEPTH))
    else $error("queue count above depth");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("push did not raise count");

endmodule

@@ src/fcc_div.sv @@
// Pipelined restoring divider: factor = sat32(H*2^40 / den), one bit a stage.
// Depends on fcc_pkg.
module fcc_div #(
  parameter int SCREEN_HEIGHT = 720
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  fcc_pkg::fcc_item_t          item_i,
  output logic                        valid_o,
  output fcc_pkg::fcc_item_t          item_o,
  output logic [fcc_pkg::FACT_W-1:0]  factor_o
);

  localparam int NS = fcc_pkg::DIV_STEPS;
  localparam int SW = fcc_pkg::DEN_W + NS;
  localparam logic [fcc_pkg::NUM_W-1:0] NUM = fcc_pkg::NUM_W'(SCREEN_HEIGHT) << 40;

  logic                        v_q   [NS+1];
  fcc_pkg::fcc_item_t          it_q  [NS+1];
  logic [fcc_pkg::NUM_W-1:0]   rem_q [NS+1];
  logic [fcc_pkg::NUM_W-1:0]   rem_d [NS+1];
  logic [NS-1:0]               quo_q [NS+1];
  logic [NS-1:0]               quo_d [NS+1];
  logic                        sat_q [NS+1];

  always_comb begin
    logic [SW-1:0] sh, ext, diff;
    rem_d[0] = NUM;
    quo_d[0] = '0;
    for (int s = 1; s <= NS; s++) begin
      sh   = {{NS{1'b0}}, it_q[s-1].den} << (NS - s);
      ext  = SW'(rem_q[s-1]);
      diff = ext - sh;
      if (ext >= sh) begin
        rem_d[s] = diff[fcc_pkg::NUM_W-1:0];
        quo_d[s] = quo_q[s-1] | (NS'(1) << (NS - s));
      end else begin
        rem_d[s] = rem_q[s-1];
        quo_d[s] = quo_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NS; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s <= NS; s++) v_q[s] <= v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it_q[0]  <= item_i;
      rem_q[0] <= rem_d[0];
      quo_q[0] <= quo_d[0];
      sat_q[0] <= SW'(NUM) >= {item_i.den, {NS{1'b0}}};
      for (int s = 1; s <= NS; s++) begin
        it_q[s]  <= it_q[s-1];
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        sat_q[s] <= sat_q[s-1];
      end
    end
  end

  assign valid_o  = v_q[NS];
  assign item_o   = it_q[NS];
  assign factor_o = sat_q[NS] ? '1 : quo_q[NS];

endmodule

@@ src/fcc_mod.sv @@
// Pipelined remainder m mod size with floored sign fix-up, one bit a stage.
// Depends on fcc_pkg.
module fcc_mod (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [fcc_pkg::M_W-1:0]     m_i,
  input  logic [fcc_pkg::SIZE_W-1:0]  size_i,
  input  logic                        neg_i,
  output logic [fcc_pkg::TEX_W-1:0]   tex_o
);

  localparam int NS = fcc_pkg::MOD_STEPS;
  localparam int SW = fcc_pkg::SIZE_W + NS;

  logic [fcc_pkg::M_W-1:0]    rem_q [NS+1];
  logic [fcc_pkg::M_W-1:0]    rem_d [NS+1];
  logic [fcc_pkg::SIZE_W-1:0] sz_q  [NS+1];
  logic                       neg_q [NS+1];
  logic [fcc_pkg::SIZE_W-1:0] r, t;

  always_comb begin
    logic [SW-1:0] sh, ext, diff;
    rem_d[0] = m_i;
    for (int s = 1; s <= NS; s++) begin
      sh   = SW'(sz_q[s-1]) << (NS - s);
      ext  = SW'(rem_q[s-1]);
      diff = ext - sh;
      rem_d[s] = (ext >= sh) ? diff[fcc_pkg::M_W-1:0] : rem_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d[0];
      sz_q[0]  <= size_i;
      neg_q[0] <= neg_i;
      for (int s = 1; s <= NS; s++) begin
        rem_q[s] <= rem_d[s];
        sz_q[s]  <= sz_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  // remainder is below size here, so it fits the size width
  always_comb begin
    r = rem_q[NS][fcc_pkg::SIZE_W-1:0];
    t = (neg_q[NS] && r != '0) ? sz_q[NS] - r : r;
    tex_o = t[fcc_pkg::TEX_W-1:0];
  end

endmodule

@@ src/fcc_back.sv @@
// Back end: factor divider, blend, texel scaling, modulo and texel index.
// Depends on fcc_pkg, fcc_div and fcc_mod.
module fcc_back #(
  parameter int SCREEN_HEIGHT = 720
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  fcc_pkg::fcc_item_t item_i,
  output logic               out_valid_o,
  output logic [10:0]        screen_x_o,
  output logic [10:0]        screen_y_o,
  output logic [9:0]         tex_x_o,
  output logic [9:0]         tex_y_o,
  output logic [19:0]        texel_index_o,
  output logic               in_range_o
);

  localparam int LAT = 4 + fcc_pkg::MOD_STEPS + 1;
  localparam int PW  = fcc_pkg::PT_W;
  localparam int FW  = fcc_pkg::FACT_W;
  localparam int CW  = fcc_pkg::CMAG_W;

  logic                        dv;
  fcc_pkg::fcc_item_t          dit;
  logic [FW-1:0]               factor;

  fcc_div #(.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en_i),
    .valid_i  (valid_i),
    .item_i   (item_i),
    .valid_o  (dv),
    .item_o   (dit),
    .factor_o (factor)
  );

  // side data delay line, aligned with the arithmetic lanes
  logic               sv_q [LAT];
  fcc_pkg::fcc_side_t sd_q [LAT];

  // lane 0 is x, lane 1 is y
  logic [PW-1:0]     mag1_q  [2];
  logic              neg1_q  [2];
  logic [23:0]       pl1_q   [2];
  logic [FW-1:0]     fac1_q;
  logic [PW+FW-1:0]  prod2_q [2];
  logic              neg2_q  [2];
  logic [23:0]       pl2_q   [2];
  logic [CW-1:0]     cmag3_q [2];
  logic              cneg3_q [2];
  logic [CW+10:0]    sp4_q   [2];
  logic              neg4_q  [2];

  logic [PW-1:0]     mag1_d  [2];
  logic              neg1_d  [2];
  logic [CW-1:0]     cmag3_d [2];
  logic              cneg3_d [2];
  logic [10:0]       size3   [2];
  logic [9:0]        tex     [2];

  always_comb begin
    logic signed [PW:0]   dd, nd;
    logic [32:0]          delta;
    logic signed [CW:0]   c, nc;
    logic [PW-1:0]        pt [2];
    logic [23:0]          pl [2];
    pt[0] = dit.fx;
    pt[1] = dit.fy;
    pl[0] = dit.px;
    pl[1] = dit.py;
    size3[0] = sd_q[2].w;
    size3[1] = sd_q[2].h;
    for (int l = 0; l < 2; l++) begin
      dd = $signed({1'b0, pt[l]}) - $signed({2'b00, pl[l]});
      nd = -dd;
      neg1_d[l] = dd[PW];
      mag1_d[l] = dd[PW] ? nd[PW-1:0] : dd[PW-1:0];

      delta = prod2_q[l][PW+FW-1:24];
      if (neg2_q[l]) c = $signed((CW+1)'(pl2_q[l])) - $signed((CW+1)'(delta));
      else           c = $signed((CW+1)'(pl2_q[l])) + $signed((CW+1)'(delta));
      nc = -c;
      cneg3_d[l] = c[CW];
      cmag3_d[l] = c[CW] ? nc[CW-1:0] : c[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LAT; s++) sv_q[s] <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en_i) begin
      sv_q[0] <= dv;
      for (int s = 1; s < LAT; s++) sv_q[s] <= sv_q[s-1];
      out_valid_o <= sv_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q[0] <= dit.side;
      for (int s = 1; s < LAT; s++) sd_q[s] <= sd_q[s-1];
      fac1_q <= factor;
      pl1_q[0] <= dit.px;
      pl1_q[1] <= dit.py;
      for (int l = 0; l < 2; l++) begin
        mag1_q[l]  <= mag1_d[l];
        neg1_q[l]  <= neg1_d[l];
        prod2_q[l] <= (PW+FW)'(mag1_q[l]) * (PW+FW)'(fac1_q);
        neg2_q[l]  <= neg1_q[l];
        pl2_q[l]   <= pl1_q[l];
        cmag3_q[l] <= cmag3_d[l];
        cneg3_q[l] <= cneg3_d[l];
        sp4_q[l]   <= (CW+11)'(cmag3_q[l]) * (CW+11)'(size3[l]);
        neg4_q[l]  <= cneg3_q[l];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    fcc_mod u_mod (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .m_i    (sp4_q[l][CW+9:16]),
      .size_i (l == 0 ? sd_q[3].w : sd_q[3].h),
      .neg_i  (neg4_q[l]),
      .tex_o  (tex[l])
    );
  end

  always_ff @(posedge clk_i) begin
    logic [20:0] idx;
    idx = 21'(tex[1]) * 21'(sd_q[LAT-1].w) + 21'(tex[0]);
    if (en_i) begin
      in_range_o    <= sd_q[LAT-1].ok;
      screen_x_o    <= sd_q[LAT-1].ok ? sd_q[LAT-1].col : '0;
      screen_y_o    <= sd_q[LAT-1].ok ? sd_q[LAT-1].sy : '0;
      tex_x_o       <= sd_q[LAT-1].ok ? tex[0] : '0;
      tex_y_o       <= sd_q[LAT-1].ok ? tex[1] : '0;
      texel_index_o <= sd_q[LAT-1].ok ? idx[19:0] : '0;
    end
  end

endmodule

@@ test/tb_floor_ceiling_texel_cast_top.sv @@
// Self-checking testbench for floor_ceiling_texel_cast_top: predicts every
// pixel result and compares it in order. Depends on fcc_pkg and the src RTL.
module tb_floor_ceiling_texel_cast_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  H         = 720;
  localparam int  WD_LIMIT  = 20000; // cycles without any handshake
  localparam int  DRAIN_CYC = 80;    // pipeline latency plus margin
  localparam logic REQ_FLOOR = 1'b0;
  localparam logic REQ_CEIL  = 1'b1;

  localparam int CFG_VO [6] = '{0, 360, -360, 511, 100, -1};
  localparam int CFG_FW [6] = '{64, 1, 1024, 0, 2047, 37};
  localparam int CFG_FH [6] = '{64, 1024, 1, 2047, 0, 200};
  localparam int CFG_CW [6] = '{64, 1024, 1, 0, 5, 999};
  localparam int CFG_CH [6] = '{64, 1, 1024, 1500, 3, 17};

  typedef struct {
    logic        req_type;
    logic [1:0]  face;
    logic [7:0]  cx, cy;
    logic [15:0] frac;
    logic [23:0] wd, px, py;
    logic [10:0] wb, y, col;
  } pixel_req_t;

  typedef struct {
    logic [10:0] sx, sy;
    logic [9:0]  tx, ty;
    logic [19:0] idx;
    logic        in_range;
  } texel_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall;
  pixel_req_t cur = '{default: '0};
  logic out_valid, out_stall = 1'b0;
  logic [10:0] screen_x, screen_y;
  logic [9:0] tex_x, tex_y;
  logic [19:0] texel_index;
  logic in_range;

  // shadow of the register file
  logic [9:0]  sh_vo   = '0;
  logic [10:0] sh_fw = 11'd64, sh_fh = 11'd64, sh_cw = 11'd64, sh_ch = 11'd64;

  pixel_req_t pending_reqs[$];
  texel_res_t expected_texels[$];
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_cycles = 0;
  int mismatches = 0, n_results = 0, quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  floor_ceiling_texel_cast_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(cur.req_type), .hit_face_i(cur.face), .cell_x_i(cur.cx),
    .cell_y_i(cur.cy), .wall_frac_i(cur.frac), .wall_dist_i(cur.wd),
    .player_x_i(cur.px), .player_y_i(cur.py), .wall_bottom_i(cur.wb),
    .row_i(cur.y), .column_i(cur.col),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .screen_x_o(screen_x), .screen_y_o(screen_y), .tex_x_o(tex_x),
    .tex_y_o(tex_y), .texel_index_o(texel_index), .in_range_o(in_range)
  );

  function automatic longint eff_size(logic [10:0] s);
    if (s == '0) return 1;
    if (s > 11'd1024) return 1024;
    return longint'(s);
  endfunction

  // player + (pt - player) * factor, factor Q8.24, truncated toward zero
  function automatic longint blend_coord(longint pt, longint pl, longint unsigned f);
    longint d;
    longint unsigned mag;
    longint delta;
    d = pt - pl;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    delta = longint'((mag * f) >> 24);
    return (d < 0) ? pl - delta : pl + delta;
  endfunction

  function automatic longint texel_coord(longint c, longint sz);
    longint unsigned mag;
    longint n, r;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    n = longint'((mag * longint'(sz)) >> 16);
    if (c < 0) n = -n;
    r = n % sz;
    if (r < 0) r += sz;
    return r;
  endfunction

  function automatic texel_res_t predict_texel(pixel_req_t r);
    texel_res_t res;
    longint vo, y, wb, fx, fy, cx, cy, w, h, sy, tx, ty;
    longint unsigned wd, den, fac;
    logic ok;
    res = '{default: '0};
    vo = longint'($signed(sh_vo));
    y = r.y;
    wb = r.wb;
    cx = longint'(r.cx) << 16;
    cy = longint'(r.cy) << 16;
    if (r.req_type == REQ_CEIL) ok = (y >= wb + 1) && (y < H + vo);
    else ok = (y >= wb - 1) && (y + vo < H);
    if (!ok || 2 * y <= H) return res;
    case (r.face)
      fcc_pkg::FACE_X_POS: begin fx = cx;         fy = cy + r.frac; end
      fcc_pkg::FACE_X_NEG: begin fx = cx + 65536; fy = cy + r.frac; end
      fcc_pkg::FACE_Y_POS: begin fx = cx + r.frac; fy = cy; end
      default:             begin fx = cx + r.frac; fy = cy + 65536; end
    endcase
    wd = (r.wd == '0) ? 1 : r.wd;
    den = longint'(2 * y - H) * wd;
    fac = (longint'(H) << 40) / den;
    if (fac > 64'hFFFF_FFFF) fac = 64'hFFFF_FFFF;
    if (r.req_type == REQ_CEIL) begin
      w = eff_size(sh_cw); h = eff_size(sh_ch); sy = H - y + vo;
    end else begin
      w = eff_size(sh_fw); h = eff_size(sh_fh); sy = y + vo;
    end
    tx = texel_coord(blend_coord(fx, r.px, fac), w);
    ty = texel_coord(blend_coord(fy, r.py, fac), h);
    res.sx = r.col;
    res.sy = sy[10:0];
    res.tx = tx[9:0];
    res.ty = ty[9:0];
    res.idx = 20'(ty * w + tx);
    res.in_range = 1'b1;
    return res;
  endfunction

  // Request driver: one NBA per signal per edge; payload frozen while stalled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_texels.push_back(predict_texel(cur));
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall generator
  always @(posedge clk) begin
    texel_res_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_texels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result sx=%0d sy=%0d", screen_x, screen_y);
        end else begin
          e = expected_texels.pop_front();
          if (e.sx !== screen_x || e.sy !== screen_y || e.tx !== tex_x ||
              e.ty !== tex_y || e.idx !== texel_index || e.in_range !== in_range) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp sx=%0d sy=%0d tx=%0d ty=%0d idx=%0d ir=%0b",
                       e.sx, e.sy, e.tx, e.ty, e.idx, e.in_range);
              $display("          got sx=%0d sy=%0d tx=%0d ty=%0d idx=%0d ir=%0b",
                       screen_x, screen_y, tex_x, tex_y, texel_index, in_range);
            end
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      fcc_pkg::REG_VIEW_OFFSET: sh_vo = val[9:0];
      fcc_pkg::REG_FLOOR_TEX_W: sh_fw = val[10:0];
      fcc_pkg::REG_FLOOR_TEX_H: sh_fh = val[10:0];
      fcc_pkg::REG_CEIL_TEX_W:  sh_cw = val[10:0];
      default:                  sh_ch = val[10:0];
    endcase
  endtask

  task automatic set_config(int vo, int fw, int fh, int cw, int ch);
    apb_write(fcc_pkg::REG_VIEW_OFFSET, 32'(vo));
    apb_write(fcc_pkg::REG_FLOOR_TEX_W, 32'(fw));
    apb_write(fcc_pkg::REG_FLOOR_TEX_H, 32'(fh));
    apb_write(fcc_pkg::REG_CEIL_TEX_W, 32'(cw));
    apb_write(fcc_pkg::REG_CEIL_TEX_H, 32'(ch));
  endtask

  // mostly cast pixels with random content; some fully random noise
  function automatic pixel_req_t rand_req(bit cast);
    pixel_req_t r;
    r.req_type = 1'($urandom_range(1));
    r.face = 2'($urandom_range(3));
    r.cx = 8'($urandom); r.cy = 8'($urandom); r.frac = 16'($urandom);
    r.wd = 24'($urandom >> $urandom_range(8, 23));
    if ($urandom_range(9) == 0) r.wd = 24'($urandom);
    r.px = 24'($urandom); r.py = 24'($urandom);
    r.col = 11'($urandom);
    if (cast) begin
      r.y = 11'($urandom_range(361, 1079));
      r.wb = 11'($urandom_range(0, r.y - 1));
    end else begin
      r.y = 11'($urandom); r.wb = 11'($urandom);
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_texels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  initial begin
    pixel_req_t r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      set_config(CFG_VO[ph], CFG_FW[ph], CFG_FH[ph], CFG_CW[ph], CFG_CH[ph]);
      send_idle_pct  = (ph < 2) ? 28 : (ph < 4) ? 78 : 0;
      recv_stall_pct = (ph < 2) ? 78 : (ph < 4) ? 28 : 0;
      if (ph == 0) begin
        // directed: faces, both kinds, range edges, zero distance, field extremes
        for (int f = 0; f < 4; f++) begin
          r = rand_req(1); r.face = 2'(f); r.req_type = REQ_FLOOR;
          pending_reqs.push_back(r);
          r.req_type = REQ_CEIL; pending_reqs.push_back(r);
        end
        r = rand_req(1); r.wd = '0; pending_reqs.push_back(r);
        r = rand_req(1); r.wd = 24'hFFFFFF; pending_reqs.push_back(r);
        r = rand_req(1); r.y = 11'd360; r.wb = 0; pending_reqs.push_back(r);
        r = rand_req(1); r.y = 11'd361; r.wb = 0; r.wd = 1; pending_reqs.push_back(r);
        r = rand_req(1); r.y = 11'd2047; r.wb = 11'd2047; pending_reqs.push_back(r);
        r = rand_req(1); r.req_type = REQ_FLOOR; r.y = 11'd400; r.wb = 11'd401;
        pending_reqs.push_back(r);
        r.wb = 11'd402; pending_reqs.push_back(r);
        r.req_type = REQ_CEIL; r.wb = 11'd399; pending_reqs.push_back(r);
        r.wb = 11'd400; pending_reqs.push_back(r);
        r = rand_req(1); r.cx = 8'hFF; r.cy = 8'hFF; r.frac = 16'hFFFF;
        r.px = '0; r.py = '0; pending_reqs.push_back(r);
        r.cx = '0; r.cy = '0; r.frac = '0; r.px = 24'hFFFFFF; r.py = 24'hFFFFFF;
        pending_reqs.push_back(r);
        r = rand_req(1); r.col = 11'h7FF; r.y = 11'd719; pending_reqs.push_back(r);
        r.y = 11'd720; pending_reqs.push_back(r);
      end
      for (int k = 0; k < 232; k++)
        pending_reqs.push_back(rand_req($urandom_range(9) < 8));
      if (ph == 4) begin
        // long receiver hold-off while requests keep coming
        repeat (10) @(posedge clk);
        hold_cycles = 300;
      end
      wait_drained();
    end
    $display("covered %0d results over 6 register settings, faces, both pixel kinds,",
             n_results);
    $display("cast-range edges, size clamping and back-pressure with a full queue");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
